@@ rtl/fas_pkg.sv @@
// Package for the approximate float square root block: constants and
// binary32 helper types. No dependencies.
package fas_pkg;
    localparam logic [31:0] SqrtGuessBias  = 32'h1FBC_F800;
    localparam logic [31:0] IsqrtGuessBias = 32'h5F37_59DF;
    localparam logic [31:0] CanonQnan      = 32'h7FC0_0000;

    // Unpacked operand: class flags, sign, unbiased exponent, significand.
    typedef struct packed {
        logic        is_nan;
        logic        is_inf;
        logic        is_zero;
        logic        sign;
        logic signed [10:0] exp;
        logic [23:0] man;
    } fas_unp_t;

    function automatic fas_unp_t fas_unpack(input logic [31:0] b);
        fas_unp_t u;
        u.sign    = b[31];
        u.is_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        u.is_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        u.is_zero = (b[30:0] == 31'd0);
        if (b[30:23] == 8'd0)
        begin
            u.exp = -11'sd126;
            u.man = {1'b0, b[22:0]};
        end
        else
        begin
            u.exp = $signed({3'b000, b[30:23]}) - 11'sd127;
            u.man = {1'b1, b[22:0]};
        end
        return u;
    endfunction

    // Round a value sign * mag * 2^(e - 26), mag < 2^27 with sticky in bit 0,
    // mag msb at position 26 (or below, already denormal-aligned).
    // Caller normalizes so that mag[26] is the leading bit when e >= -126.
    function automatic logic [31:0] fas_round(input logic s, input logic signed [11:0] e,
                                              input logic [26:0] m);
        logic [26:0] a;
        logic [4:0]  sh;
        logic        st;
        logic [24:0] r;
        logic [8:0]  be;
        logic        inc;
        a  = m;
        sh = 5'd0;
        if (e < -12'sd126)
        begin
            if (e < -12'sd152)
                sh = 5'd27;
            else
                sh = 5'(-12'sd126 - e);
        end
        st  = |(a & ((27'd1 << sh) - 27'd1));
        a   = (sh == 5'd27) ? 27'd0 : (a >> sh);
        a[0] = a[0] | st;
        inc = a[2] && (a[1] || a[0] || a[3]);
        r   = {1'b0, a[26:3]} + 25'(inc);
        if (e < -12'sd126)
            be = 9'(r[23]);
        else
            be = 9'(e + 12'sd127);
        if (r[24])
        begin
            r  = r >> 1;
            be = be + 9'd1;
        end
        if (e > 12'sd127 || be >= 9'd255)
            return {s, 8'hFF, 23'd0};
        return {s, be[7:0], r[22:0]};
    endfunction

    // Halves a binary32 value. Normal results only lose one from the exponent;
    // results that land in the subnormal range are shifted and rounded to
    // nearest even. Infinities and NaNs pass unchanged.
    function automatic logic [31:0] fas_half(input logic [31:0] b);
        logic [23:0] m;
        logic [23:0] r;
        m = {(b[30:23] != 8'd0), b[22:0]};
        r = {1'b0, m[23:1]} + 24'(m[0] & m[1]);
        if (b[30:23] == 8'hFF)
            return b;
        if (b[30:23] > 8'd1)
            return {b[31], b[30:23] - 8'd1, b[22:0]};
        return {b[31], 7'd0, r};
    endfunction
endpackage

@@ rtl/fast_approx_float_sqrt.sv @@
// Top level of the approximate float square root: a six-stage pipeline.
// Depends on fas_pkg for constants and binary32 unpack/round helpers.
//
// The block takes one binary32 bit pattern a cycle and returns
// 0.5 * (g1 + x * g2), where g1 and g2 are the integer-derived square-root
// and inverse-square-root guesses. One request is
// accepted every cycle as long as the output side takes results. Stages: guess
// forming and unpacking, 24x24 multiply, product rounding, add alignment and
// sum, sum normalization and rounding, halving (which rounds again when the
// result falls into the subnormal range). A stall freezes all stages together,
// so the output register doubles as the skid point. NaN results come out as
// 0x7FC00000.
module fast_approx_float_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value_bits
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] root_bits
);
    import fas_pkg::*;

    logic [5:0] vld_reg;
    logic       adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[5];

    // stage 1
    fas_unp_t   x1_reg, g21_reg;
    logic [31:0] g11_reg;
    // stage 2
    logic [47:0] p2_reg;
    logic        ps2_reg, pnan2_reg, pinf2_reg, pz2_reg;
    logic signed [11:0] pe2_reg;
    logic [31:0] g12_reg;
    // stage 3
    logic [31:0] pb3_reg, g13_reg;
    // stage 4
    logic        s4_reg, nan4_reg, inf4_reg, zero4_reg, zs4_reg;
    logic signed [11:0] e4_reg;
    logic [27:0] m4_reg;
    // stage 5
    logic [31:0] sum5_reg;
    // stage 6
    logic [31:0] out_reg;

    logic [31:0] half, g1b, g2b;
    always_comb
    begin
        half = {s_tdata[31], s_tdata[31:1]};
        g1b  = SqrtGuessBias + half;
        g2b  = IsqrtGuessBias - half;
    end

    // product normalization
    logic [47:0] pn;
    logic [5:0]  lz;
    logic [26:0] pm;
    logic signed [11:0] pe;
    always_comb
    begin
        lz = 6'd0;
        for (int i = 0; i < 48; i++)
            if (p2_reg[i])
                lz = 6'(47 - i);
        pn = p2_reg << lz;
        pm = {pn[47:22], |pn[21:0]};
        pe = pe2_reg - 12'(lz);
    end

    // addition
    fas_unp_t a, b, big, sml;
    logic [11:0] d;
    logic [27:0] bm, sm, sum;
    logic [52:0] ext;
    logic        eff_sub;
    always_comb
    begin
        a = fas_unpack(g13_reg);
        b = fas_unpack(pb3_reg);
        // For finite values the magnitude order is the order of the raw bits.
        if (g13_reg[30:0] >= pb3_reg[30:0])
        begin
            big = a; sml = b;
        end
        else
        begin
            big = b; sml = a;
        end
        d   = 12'(big.exp - sml.exp);
        bm  = {1'b0, big.man, 3'b000};
        ext = {1'b0, sml.man, 28'd0} >> ((d > 12'd40) ? 12'd40 : d);
        sm  = ext[52:25];
        sm[0] = sm[0] | (|ext[24:0]);
        eff_sub = big.sign ^ sml.sign;
        sum = eff_sub ? bm - sm : bm + sm;
    end

    // sum normalization
    logic [27:0] sn;
    logic [4:0]  sl;
    logic [26:0] sr;
    logic signed [11:0] se;
    always_comb
    begin
        sn = 28'd0;
        sl = 5'd0;
        for (int i = 0; i < 27; i++)
            if (m4_reg[i])
                sl = 5'(26 - i);
        if (m4_reg[27])
        begin
            sr = {m4_reg[27:2], |m4_reg[1:0]};
            se = e4_reg;
        end
        else
        begin
            sn = m4_reg << sl;
            se = e4_reg - 12'sd1 - 12'(sl);
            if (se < -12'sd127)
            begin
                sn = m4_reg << 5'(12'(sl) - (-12'sd127 - se));
                se = -12'sd127;
            end
            sr = {sn[26:1], sn[0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 6'd0;
        else if (adv)
            vld_reg <= {vld_reg[4:0], s_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg  <= fas_unpack(s_tdata);
            g21_reg <= fas_unpack(g2b);
            g11_reg <= g1b;

            p2_reg    <= x1_reg.man * g21_reg.man;
            ps2_reg   <= x1_reg.sign ^ g21_reg.sign;
            pnan2_reg <= x1_reg.is_nan || g21_reg.is_nan ||
                         (x1_reg.is_inf && g21_reg.is_zero) ||
                         (x1_reg.is_zero && g21_reg.is_inf);
            pinf2_reg <= x1_reg.is_inf || g21_reg.is_inf;
            pz2_reg   <= x1_reg.is_zero || g21_reg.is_zero;
            pe2_reg   <= 12'(x1_reg.exp) + 12'(g21_reg.exp) + 12'sd1;
            g12_reg   <= g11_reg;

            if (pnan2_reg)
                pb3_reg <= CanonQnan;
            else if (pinf2_reg)
                pb3_reg <= {ps2_reg, 8'hFF, 23'd0};
            else if (pz2_reg || p2_reg == 48'd0)
                pb3_reg <= {ps2_reg, 31'd0};
            else
                pb3_reg <= fas_round(ps2_reg, pe, pm);
            g13_reg <= g12_reg;

            nan4_reg  <= a.is_nan || b.is_nan ||
                         (a.is_inf && b.is_inf && (a.sign != b.sign));
            inf4_reg  <= a.is_inf || b.is_inf;
            s4_reg    <= a.is_inf ? a.sign : (b.is_inf ? b.sign : big.sign);
            zero4_reg <= (sum == 28'd0);
            zs4_reg   <= a.sign & b.sign;
            e4_reg    <= 12'(big.exp) + 12'sd1;
            m4_reg    <= sum;

            // The sum is rounded to binary32 on its own before it is halved.
            if (nan4_reg)
                sum5_reg <= CanonQnan;
            else if (inf4_reg)
                sum5_reg <= {s4_reg, 8'hFF, 23'd0};
            else if (zero4_reg)
                sum5_reg <= {zs4_reg, 31'd0};
            else
                sum5_reg <= fas_round(s4_reg, se, sr);

            out_reg <= fas_half(sum5_reg);
        end
    end

    assign m_tdata = out_reg;

    ap_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(vld_reg) && $stable(out_reg))
        else $error("pipeline moved during stall");
    ap_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("ready low with empty output");
    ap_flow: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> vld_reg[1] == $past(vld_reg[0]))
        else $error("valid bit lost between stages");
endmodule

@@ verif/fast_approx_float_sqrt_tb.sv @@
// Testbench for fast_approx_float_sqrt: drives binary32 requests with random gaps and
// back-pressure, and checks each root against a bit-exact binary32 predictor.
// Depends on fas_pkg for the guess constants and the canonical NaN.
`timescale 1ns / 1ps

module fast_approx_float_sqrt_tb;
    import fas_pkg::*;

    localparam int NumRandom   = 1200;
    localparam int CycleLimit  = 400000;
    localparam int NumDirected = 20;
    localparam logic [31:0] OneHalf = 32'h3F00_0000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    // Expected roots, oldest first.
    logic [31:0] root_q[$];
    int          mismatches;
    int          sent;
    int          cycles;
    logic        cur_typed;
    logic [31:0] cur_root;

    fast_approx_float_sqrt dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Binary32 arithmetic, round to nearest even, with gradual underflow.
    // Every NaN comes back as the canonical quiet NaN.
    // ------------------------------------------------------------------
    function automatic logic is_nan32(input logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf32(input logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    endfunction

    // Splits a finite value into its unbiased exponent and 24-bit significand.
    function automatic void split32(input logic [31:0] b, output int ex,
                                    output logic [23:0] m);
        if (b[30:23] == 8'd0)
        begin
            ex = -126;
            m  = {1'b0, b[22:0]};
        end
        else
        begin
            ex = int'(b[30:23]) - 127;
            m  = {1'b1, b[22:0]};
        end
    endfunction

    // Rounds sign * mag * 2^e (mag nonzero) to binary32.
    function automatic logic [31:0] round32(input logic s, input int e, input logic [63:0] mag);
        int           lead;
        int           q;
        int           sh;
        int           biased;
        logic [127:0] t;
        logic [63:0]  r;
        logic         g;
        logic         st;
        lead = 0;
        for (int i = 0; i < 64; i++)
            if (mag[i])
                lead = i;
        // q is the weight of the last kept bit; it bottoms out at the subnormal step.
        q  = (lead + e - 23 < -149) ? -149 : lead + e - 23;
        sh = q - e;
        if (sh <= 0)
        begin
            r  = mag << (-sh);
            g  = 1'b0;
            st = 1'b0;
        end
        else if (sh > 127)
        begin
            r  = 64'd0;
            g  = 1'b0;
            st = 1'b1;
        end
        else
        begin
            t  = {mag, 64'd0} >> sh;
            r  = t[127:64];
            g  = t[63];
            st = |t[62:0];
        end
        if (g && (st || r[0]))
            r = r + 64'd1;
        if (r[24])
        begin
            r = r >> 1;
            q = q + 1;
        end
        biased = r[23] ? q + 150 : 0;
        if (biased >= 255)
            return {s, 8'hFF, 23'd0};
        return {s, biased[7:0], r[22:0]};
    endfunction

    function automatic logic [31:0] fmul32(input logic [31:0] a, input logic [31:0] b);
        int          ea;
        int          eb;
        logic [23:0] ma;
        logic [23:0] mb;
        logic        s;
        s = a[31] ^ b[31];
        if (is_nan32(a) || is_nan32(b))
            return CanonQnan;
        if ((is_inf32(a) && b[30:0] == 31'd0) || (is_inf32(b) && a[30:0] == 31'd0))
            return CanonQnan;
        if (is_inf32(a) || is_inf32(b))
            return {s, 8'hFF, 23'd0};
        if (a[30:0] == 31'd0 || b[30:0] == 31'd0)
            return {s, 31'd0};
        split32(a, ea, ma);
        split32(b, eb, mb);
        return round32(s, ea + eb - 46, 64'(ma) * 64'(mb));
    endfunction

    function automatic logic [31:0] fadd32(input logic [31:0] a, input logic [31:0] b);
        int           ea;
        int           eb;
        int           d;
        logic [23:0]  ma;
        logic [23:0]  mb;
        logic [31:0]  tmp;
        logic [63:0]  big;
        logic [63:0]  sml;
        logic [63:0]  mag;
        logic [127:0] t;
        if (is_nan32(a) || is_nan32(b))
            return CanonQnan;
        if (is_inf32(a) && is_inf32(b))
            return (a[31] != b[31]) ? CanonQnan : a;
        if (is_inf32(a))
            return a;
        if (is_inf32(b))
            return b;
        if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
            return {a[31] & b[31], 31'd0};
        if (a[30:0] == 31'd0)
            return b;
        if (b[30:0] == 31'd0)
            return a;
        // Put the larger magnitude in a; the sum takes its sign.
        if (a[30:0] < b[30:0])
        begin
            tmp = a;
            a   = b;
            b   = tmp;
        end
        split32(a, ea, ma);
        split32(b, eb, mb);
        d   = ea - eb;
        big = 64'(ma) << 30;
        // Thirty guard bits plus a sticky bit keep the final rounding exact.
        if (d >= 56)
            sml = 64'd1;
        else
        begin
            t   = {64'(mb) << 30, 64'd0} >> d;
            sml = t[127:64] | 64'(|t[63:0]);
        end
        mag = (a[31] == b[31]) ? big + sml : big - sml;
        if (mag == 64'd0)
            return 32'd0;
        return round32(a[31], ea - 53, mag);
    endfunction

    // Approximate root: 0.5 * (g1 + x * g2) from the two integer guesses.
    function automatic logic [31:0] predict_root(input logic [31:0] x);
        logic [31:0] half;
        logic [31:0] g1;
        logic [31:0] g2;
        half = {x[31], x[31:1]};
        g1   = SqrtGuessBias + half;
        g2   = IsqrtGuessBias - half;
        return fmul32(OneHalf, fadd32(g1, fmul32(x, g2)));
    endfunction

    // A mix of wide random patterns and the interesting binary32 classes.
    function automatic logic [31:0] random_value();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            4, 5, 6: v = {1'b0, 8'($urandom_range(60, 200)), v[22:0]};
            7:       v = {v[31], 8'd0, ($urandom_range(0, 3) == 0) ? 23'd0 : v[22:0]};
            8:       v = {v[31], 8'hFF, ($urandom_range(0, 1) == 0) ? 23'd0 : v[22:0]};
            9:       v = {1'b1, 8'($urandom_range(100, 160)), v[22:0]};
            default: ;
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard. Both handshakes are sampled at the rising edge; the
    // result is checked before the new request is predicted.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (root_q.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected result %h", m_tdata);
            end
            else
            begin
                if (m_tdata !== root_q[0])
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("root_bits mismatch: expected %h, got %h", root_q[0], m_tdata);
                end
                void'(root_q.pop_front());
            end
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            root_q.push_back(cur_typed ? cur_root : predict_root(s_tdata));
            sent = sent + 1;
        end
    end

    always @(posedge clk)
    begin
        if (cycles > CycleLimit)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: random back-pressure, with one long hold-off once the stream is
    // well under way so that the pipeline fills and stalls its input.
    initial
    begin
        int held;
        int pick;
        held = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sent >= 300 && held == 0)
            begin
                held = 1;
                m_tready <= 1'b0;
                repeat (80) @(negedge clk);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if ((sent / 150) % 3 == 2)
                    m_tready <= 1'b1;
                else if (pick < 3)
                begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(negedge clk);
                end
                else
                    m_tready <= (pick >= 30);
            end
        end
    end

    // Offers one request and holds it until the block takes it.
    task automatic offer(input logic [31:0] v, input logic typed, input logic [31:0] root);
        s_tdata   <= v;
        cur_typed <= typed;
        cur_root  <= root;
        s_tvalid  <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Random gap before a request; bursts with no gaps every few hundred items.
    task automatic idle_gap(input int n);
        int len;
        int pick;
        pick = $urandom_range(0, 99);
        if ((n / 100) % 4 == 1)
            len = 0;
        else if (pick < 55)
            len = 0;
        else if (pick < 95)
            len = $urandom_range(1, 3);
        else
            len = $urandom_range(10, 40);
        if (len > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (len) @(negedge clk);
        end
    endtask

    // Directed rows: extremes, zeros, subnormals, infinities and NaNs. Only
    // rows whose root is obvious have it typed in; the rest use the predictor.
    logic [31:0] dir_in    [NumDirected] = '{
        32'h0000_0000, 32'h7FC0_0000, 32'h7F80_0000, 32'hFFFF_FFFF, 32'h7F80_0001,
        32'h8000_0000, 32'h0000_0001, 32'h007F_FFFF, 32'h0080_0000, 32'h7F7F_FFFF,
        32'hFF80_0000, 32'h3F80_0000, 32'h4080_0000, 32'hBF80_0000, 32'h8000_0001,
        32'h5F37_59DF, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFF7F_FFFF, 32'h807F_FFFF
    };
    logic        dir_typed [NumDirected] = '{
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
    };
    logic [31:0] dir_root  [NumDirected] = '{
        32'h1F3C_F800, CanonQnan, 32'h7F80_0000, CanonQnan, CanonQnan,
        32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
        32'd0, 32'd0, 32'd0, 32'd0, 32'd0
    };

    initial
    begin
        int waited;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 32'd0;
        cur_typed  = 1'b0;
        cur_root   = 32'd0;
        mismatches = 0;
        sent       = 0;
        cycles     = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < NumDirected; i++)
        begin
            idle_gap(i);
            offer(dir_in[i], dir_typed[i], dir_root[i]);
        end

        for (int i = 0; i < NumRandom; i++)
        begin
            // Midway, the sender pauses until every root has come back.
            if (i == 700)
            begin
                s_tvalid <= 1'b0;
                wait (root_q.size() == 0);
                @(negedge clk);
            end
            idle_gap(i);
            offer(random_value(), 1'b0, 32'd0);
        end
        s_tvalid <= 1'b0;

        wait (root_q.size() == 0);
        waited = 0;
        while (waited < 20)
        begin
            @(posedge clk);
            waited = waited + 1;
        end
        if (mismatches == 0 && root_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/fas_pkg.sv
rtl/fast_approx_float_sqrt.sv
verif/fast_approx_float_sqrt_tb.sv
